// ===== sv/pcrm_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pcrm_pkg
// Shared types and constants for the crop and red-mask preprocessing pipeline.
// ----------------------------------------------------------------------------
package pcrm_pkg;

    typedef enum logic [1:0] {
        MODE_PASS     = 2'd0,
        MODE_SIMPLE   = 2'd1,
        MODE_HSV      = 2'd2,
        MODE_PASS_ALT = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        CFG_MODE           = 3'd0,
        CFG_SIMPLE_RED_MIN = 3'd1,
        CFG_SIMPLE_MARGIN  = 3'd2,
        CFG_HUE_LOW_MAX    = 3'd3,
        CFG_HUE_HIGH_MIN   = 3'd4,
        CFG_SAT_MIN        = 3'd5,
        CFG_VALUE_MIN      = 3'd6
    } t_cfg_idx;

    typedef enum logic [1:0] {
        HUE_RED   = 2'd0,
        HUE_GREEN = 2'd1,
        HUE_BLUE  = 2'd2
    } t_hue_base;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 9;
    localparam int unsigned DIV_STAGES = 4;

    localparam t_mode      RST_MODE           = MODE_HSV;
    localparam logic [7:0] RST_SIMPLE_RED_MIN = 8'd150;
    localparam logic [7:0] RST_SIMPLE_MARGIN  = 8'd60;
    localparam logic [8:0] RST_HUE_LOW_MAX    = 9'd10;
    localparam logic [8:0] RST_HUE_HIGH_MIN   = 9'd348;
    localparam logic [7:0] RST_SAT_MIN        = 8'd110;
    localparam logic [7:0] RST_VALUE_MIN      = 8'd60;

    localparam logic [15:0] RED_CROP    = 16'hF800;
    localparam logic [23:0] RED_FEATURE = 24'hFF0000;

    // Luma weights in 16-bit fixed point.
    localparam logic [15:0] GRAY_KR = 16'd19595;
    localparam logic [15:0] GRAY_KG = 16'd38470;
    localparam logic [15:0] GRAY_KB = 16'd7471;

    localparam logic [8:0] HUE_360 = 9'd360;
    localparam logic [8:0] HUE_120 = 9'd120;
    localparam logic [8:0] HUE_240 = 9'd240;
    localparam logic [7:0] HUE_60  = 8'd60;

    typedef struct packed {
        t_mode      mode;
        logic [7:0] simple_red_min;
        logic [7:0] simple_margin;
        logic [8:0] hue_low_max;
        logic [8:0] hue_high_min;
        logic [7:0] sat_min;
        logic [7:0] value_min;
    } t_cfg;

    // Beat leaving the window stage.
    typedef struct packed {
        logic [15:0] pix;
        logic [7:0]  r;
        logic [7:0]  g;
        logic [7:0]  b;
        logic [7:0]  cx;
        logic [6:0]  cy;
        logic        last;
    } t_front;

    // Sideband that travels alongside the dividers.
    typedef struct packed {
        logic [15:0] pix;
        logic [7:0]  r;
        logic [7:0]  g;
        logic [7:0]  b;
        logic [13:0] idx;
        logic        last;
        logic        simple_red;
        logic [7:0]  mx;
        t_hue_base   hue_base;
        logic        hue_neg;
        logic        hue_zero;
        logic        sat_zero;
        logic [7:0]  gray;
    } t_side;

    typedef struct packed {
        t_side       side;
        logic [23:0] gray_pr;
        logic [23:0] gray_pg;
        logic [23:0] gray_pb;
        logic [15:0] hue_num;
        logic [7:0]  hue_den;
        logic [15:0] sat_num;
        logic [7:0]  sat_den;
    } t_prep;

endpackage
`default_nettype wire

// ===== sv/pixel_crop_red_mask_preprocess.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pixel_crop_red_mask_preprocess
// Crops a centred window out of an RGB565 pixel stream and applies a
// pass-through, simple red threshold or HSV red mask with grayscale fallback.
// ----------------------------------------------------------------------------
//  channel  direction  handshake                  payload
//  in       sink       i_in_valid / o_in_ready    i_pixel, i_col, i_row
//  out      source     o_out_valid / i_out_ready  o_disp_pixel, o_feature_rgb,
//                                                 o_crop_index, o_last_of_crop
//  cfg      sink       i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// One beat enters per clock while o_in_ready is high; a result is valid
// once its beat has passed seven registers: window, operands, four divider
// stages of two quotient bits each, and the output. Beats outside the window
// leave the pipeline at the first stage. Each stage moves when it is empty or
// the next one moves, so a stall at the output fills bubbles before it holds
// back the input. Reset empties the pipeline and loads the register defaults.
// ----------------------------------------------------------------------------
module pixel_crop_red_mask_preprocess
    import pcrm_pkg::*;
#(
    parameter int FRAME_WIDTH  = 160,
    parameter int FRAME_HEIGHT = 120,
    parameter int CROP_WIDTH   = 96,
    parameter int CROP_HEIGHT  = 96
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire logic [15:0]           i_pixel,
    input  wire logic [7:0]            i_col,
    input  wire logic [6:0]            i_row,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output logic [15:0]                o_disp_pixel,
    output logic [23:0]                o_feature_rgb,
    output logic [13:0]                o_crop_index,
    output logic                       o_last_of_crop,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg   r_cfg;
    t_front front_data;
    logic   front_valid;
    t_prep  prep_data;
    logic   prep_valid;
    logic   en_front;
    logic   en_prep;
    logic   en_back;
    logic   [DIV_STAGES-1:0] en_div;
    logic   [DIV_STAGES-1:0] r_div_valid;
    t_side  r_side [DIV_STAGES];
    t_side  n_side0;
    logic   [7:0] hue_q;
    logic   [7:0] sat_q;
    logic   [23:0] gray_sum;

    // ---- Configuration registers ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode           <= RST_MODE;
            r_cfg.simple_red_min <= RST_SIMPLE_RED_MIN;
            r_cfg.simple_margin  <= RST_SIMPLE_MARGIN;
            r_cfg.hue_low_max    <= RST_HUE_LOW_MAX;
            r_cfg.hue_high_min   <= RST_HUE_HIGH_MIN;
            r_cfg.sat_min        <= RST_SAT_MIN;
            r_cfg.value_min      <= RST_VALUE_MIN;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_MODE:           r_cfg.mode           <= t_mode'(i_cfg_data[1:0]);
                CFG_SIMPLE_RED_MIN: r_cfg.simple_red_min <= i_cfg_data[7:0];
                CFG_SIMPLE_MARGIN:  r_cfg.simple_margin  <= i_cfg_data[7:0];
                CFG_HUE_LOW_MAX:    r_cfg.hue_low_max    <= i_cfg_data[8:0];
                CFG_HUE_HIGH_MIN:   r_cfg.hue_high_min   <= i_cfg_data[8:0];
                CFG_SAT_MIN:        r_cfg.sat_min        <= i_cfg_data[7:0];
                CFG_VALUE_MIN:      r_cfg.value_min      <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // ---- Stage enables: a stage moves when it is empty or its successor moves ----
    always_comb begin
        en_back = !o_out_valid || i_out_ready;
        en_div[DIV_STAGES-1] = !r_div_valid[DIV_STAGES-1] || en_back;
        for (int s = DIV_STAGES - 2; s >= 0; s--) begin
            en_div[s] = !r_div_valid[s] || en_div[s+1];
        end
        en_prep  = !prep_valid || en_div[0];
        en_front = !front_valid || en_prep;
    end

    assign o_in_ready = en_front;

    pcrm_front #(
        .FRAME_WIDTH  (FRAME_WIDTH),
        .FRAME_HEIGHT (FRAME_HEIGHT),
        .CROP_WIDTH   (CROP_WIDTH),
        .CROP_HEIGHT  (CROP_HEIGHT)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en_front),
        .i_valid (i_in_valid),
        .i_pixel (i_pixel),
        .i_col   (i_col),
        .i_row   (i_row),
        .o_valid (front_valid),
        .o_data  (front_data)
    );

    pcrm_prep #(
        .CROP_WIDTH (CROP_WIDTH)
    ) u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en_prep),
        .i_valid (front_valid),
        .i_data  (front_data),
        .i_cfg   (r_cfg),
        .o_valid (prep_valid),
        .o_data  (prep_data)
    );

    pcrm_div u_div_hue (
        .i_clk (i_clk),
        .i_en  (en_div),
        .i_num (prep_data.hue_num),
        .i_den (prep_data.hue_den),
        .o_quo (hue_q)
    );

    pcrm_div u_div_sat (
        .i_clk (i_clk),
        .i_en  (en_div),
        .i_num (prep_data.sat_num),
        .i_den (prep_data.sat_den),
        .o_quo (sat_q)
    );

    // The luma sum is finished as the beat enters the divider stages.
    always_comb begin
        gray_sum     = prep_data.gray_pr + prep_data.gray_pg + prep_data.gray_pb;
        n_side0      = prep_data.side;
        n_side0.gray = gray_sum[23:16];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_valid <= '0;
        end else begin
            for (int s = 0; s < DIV_STAGES; s++) begin
                if (en_div[s]) begin
                    r_div_valid[s] <= (s == 0) ? prep_valid
                                               : r_div_valid[(s == 0) ? 0 : s - 1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int s = 0; s < DIV_STAGES; s++) begin
            if (en_div[s]) begin
                r_side[s] <= (s == 0) ? n_side0 : r_side[(s == 0) ? 0 : s - 1];
            end
        end
    end

    pcrm_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (en_back),
        .i_valid        (r_div_valid[DIV_STAGES-1]),
        .i_side         (r_side[DIV_STAGES-1]),
        .i_hue_q        (hue_q),
        .i_sat_q        (sat_q),
        .i_cfg          (r_cfg),
        .o_valid        (o_out_valid),
        .o_disp_pixel   (o_disp_pixel),
        .o_feature_rgb  (o_feature_rgb),
        .o_crop_index   (o_crop_index),
        .o_last_of_crop (o_last_of_crop)
    );

endmodule
`default_nettype wire

// ===== sv/pcrm_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pcrm_front
// Crop window test, window coordinates and RGB565 to RGB888 expansion.
// ----------------------------------------------------------------------------
module pcrm_front
    import pcrm_pkg::*;
#(
    parameter int FRAME_WIDTH  = 160,
    parameter int FRAME_HEIGHT = 120,
    parameter int CROP_WIDTH   = 96,
    parameter int CROP_HEIGHT  = 96
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_en,
    input  wire logic        i_valid,
    input  wire logic [15:0] i_pixel,
    input  wire logic [7:0]  i_col,
    input  wire logic [6:0]  i_row,
    output logic             o_valid,
    output t_front           o_data
);

    localparam logic [31:0] FW = 32'(FRAME_WIDTH);
    localparam logic [31:0] FH = 32'(FRAME_HEIGHT);
    localparam logic [31:0] CW = 32'(CROP_WIDTH);
    localparam logic [31:0] CH = 32'(CROP_HEIGHT);
    localparam logic [31:0] SX = (FW >= CW) ? (FW - CW) / 2 : 32'd0;
    localparam logic [31:0] SY = (FH >= CH) ? (FH - CH) / 2 : 32'd0;

    logic        r_valid;
    t_front      r_data;
    logic        n_valid;
    t_front      n_data;
    logic [31:0] col_w;
    logic [31:0] row_w;
    logic [31:0] cx_w;
    logic [31:0] cy_w;
    logic        in_win;
    logic [4:0]  r5;
    logic [5:0]  g6;
    logic [4:0]  b5;

    always_comb begin
        col_w = {24'd0, i_col};
        row_w = {25'd0, i_row};
        cx_w  = col_w - SX;
        cy_w  = row_w - SY;
        // The subtractions only count once the start tests have passed.
        in_win = (col_w < FW) && (row_w < FH) && (col_w >= SX) && (row_w >= SY)
              && (cx_w < CW) && (cy_w < CH);
        r5 = i_pixel[15:11];
        g6 = i_pixel[10:5];
        b5 = i_pixel[4:0];

        n_valid     = i_valid && in_win;
        n_data.pix  = i_pixel;
        n_data.r    = {r5, r5[4:2]};
        n_data.g    = {g6, g6[5:4]};
        n_data.b    = {b5, b5[4:2]};
        n_data.cx   = cx_w[7:0];
        n_data.cy   = cy_w[6:0];
        n_data.last = (cx_w == CW - 32'd1) && (cy_w == CH - 32'd1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule
`default_nettype wire

// ===== sv/pcrm_prep.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pcrm_prep
// Channel extremes, divider operands, luma products, simple threshold and
// crop index.
// ----------------------------------------------------------------------------
module pcrm_prep
    import pcrm_pkg::*;
#(
    parameter int CROP_WIDTH = 96
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_en,
    input  wire logic   i_valid,
    input  wire t_front i_data,
    input  wire t_cfg   i_cfg,
    output logic        o_valid,
    output t_prep       o_data
);

    localparam logic [31:0] CW32 = 32'(CROP_WIDTH);
    localparam logic [13:0] CW14 = CW32[13:0];

    logic       r_valid;
    t_prep      r_data;
    t_prep      n_data;
    logic       sel_r;
    logic       sel_g;
    logic [7:0] mx;
    logic [7:0] mn;
    logic [7:0] d;
    logic [7:0] op_a;
    logic [7:0] op_b;
    logic [7:0] mag;
    logic [8:0] g_m;
    logic [8:0] b_m;

    always_comb begin
        // Ties go to red first, then green.
        sel_r = (i_data.r >= i_data.g) && (i_data.r >= i_data.b);
        sel_g = !sel_r && (i_data.g >= i_data.b);
        mx = sel_r ? i_data.r : (sel_g ? i_data.g : i_data.b);
        if ((i_data.r <= i_data.g) && (i_data.r <= i_data.b)) begin
            mn = i_data.r;
        end else if (i_data.g <= i_data.b) begin
            mn = i_data.g;
        end else begin
            mn = i_data.b;
        end
        d = mx - mn;

        if (sel_r) begin
            op_a = i_data.g;
            op_b = i_data.b;
        end else if (sel_g) begin
            op_a = i_data.b;
            op_b = i_data.r;
        end else begin
            op_a = i_data.r;
            op_b = i_data.g;
        end
        mag = (op_a < op_b) ? (op_b - op_a) : (op_a - op_b);

        g_m = {1'b0, i_data.g} + {1'b0, i_cfg.simple_margin};
        b_m = {1'b0, i_data.b} + {1'b0, i_cfg.simple_margin};

        n_data.side.pix        = i_data.pix;
        n_data.side.r          = i_data.r;
        n_data.side.g          = i_data.g;
        n_data.side.b          = i_data.b;
        n_data.side.idx        = 14'({7'd0, i_data.cy} * CW14) + {6'd0, i_data.cx};
        n_data.side.last       = i_data.last;
        n_data.side.simple_red = (i_data.r > i_cfg.simple_red_min)
                              && ({1'b0, i_data.r} > g_m) && ({1'b0, i_data.r} > b_m);
        n_data.side.mx         = mx;
        n_data.side.hue_base   = sel_r ? HUE_RED : (sel_g ? HUE_GREEN : HUE_BLUE);
        n_data.side.hue_neg    = op_a < op_b;
        n_data.side.hue_zero   = (d == 8'd0);
        n_data.side.sat_zero   = (mx == 8'd0);
        n_data.side.gray       = 8'd0;

        n_data.gray_pr = {8'd0, GRAY_KR} * {16'd0, i_data.r};
        n_data.gray_pg = {8'd0, GRAY_KG} * {16'd0, i_data.g};
        n_data.gray_pb = {8'd0, GRAY_KB} * {16'd0, i_data.b};
        n_data.hue_num = 16'({8'd0, mag} * {8'd0, HUE_60});
        n_data.hue_den = d;
        n_data.sat_num = {d, 8'd0} - {8'd0, d};
        n_data.sat_den = mx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule
`default_nettype wire

// ===== sv/pcrm_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pcrm_div
// Pipelined restoring divider: 16-bit dividend, 8-bit divisor, 8-bit quotient,
// two quotient bits per stage. The quotient must be known to fit in 8 bits.
// ----------------------------------------------------------------------------
module pcrm_div
    import pcrm_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic [DIV_STAGES-1:0] i_en,
    input  wire logic [15:0]           i_num,
    input  wire logic [7:0]            i_den,
    output logic [7:0]                 o_quo
);

    logic [15:0] r_rem [DIV_STAGES];
    logic [7:0]  r_den [DIV_STAGES];
    logic [7:0]  r_quo [DIV_STAGES];
    logic [15:0] n_rem [DIV_STAGES];
    logic [7:0]  n_quo [DIV_STAGES];

    always_comb begin
        logic [15:0] rem;
        logic [7:0]  den;
        logic [7:0]  quo;
        logic [15:0] shd;
        for (int s = 0; s < DIV_STAGES; s++) begin
            rem = (s == 0) ? i_num : r_rem[(s == 0) ? 0 : s - 1];
            den = (s == 0) ? i_den : r_den[(s == 0) ? 0 : s - 1];
            quo = (s == 0) ? 8'd0  : r_quo[(s == 0) ? 0 : s - 1];
            for (int k = 1; k >= 0; k--) begin
                shd = {8'd0, den} << (2 * (DIV_STAGES - 1 - s) + k);
                if (rem >= shd) begin
                    rem = rem - shd;
                    quo[2 * (DIV_STAGES - 1 - s) + k] = 1'b1;
                end
            end
            n_rem[s] = rem;
            n_quo[s] = quo;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int s = 0; s < DIV_STAGES; s++) begin
            if (i_en[s]) begin
                r_rem[s] <= n_rem[s];
                r_quo[s] <= n_quo[s];
                r_den[s] <= (s == 0) ? i_den : r_den[(s == 0) ? 0 : s - 1];
            end
        end
    end

    assign o_quo = r_quo[DIV_STAGES-1];

endmodule
`default_nettype wire

// ===== sv/pcrm_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pcrm_back
// Hue reconstruction, red decision, mode selection and the output register.
// ----------------------------------------------------------------------------
module pcrm_back
    import pcrm_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_en,
    input  wire logic        i_valid,
    input  wire t_side       i_side,
    input  wire logic [7:0]  i_hue_q,
    input  wire logic [7:0]  i_sat_q,
    input  wire t_cfg        i_cfg,
    output logic             o_valid,
    output logic [15:0]      o_disp_pixel,
    output logic [23:0]      o_feature_rgb,
    output logic [13:0]      o_crop_index,
    output logic             o_last_of_crop
);

    logic        r_valid;
    logic [15:0] r_crop;
    logic [23:0] r_feat;
    logic [13:0] r_idx;
    logic        r_last;
    logic [15:0] n_crop;
    logic [23:0] n_feat;
    logic [8:0]  q9;
    logic [8:0]  hue;
    logic [7:0]  sat;
    logic        hsv_red;

    always_comb begin
        q9 = {1'b0, i_hue_q};
        case (i_side.hue_base)
            HUE_RED: begin
                // A negative quotient that truncates to zero stays at zero.
                if (i_side.hue_neg && (q9 != 9'd0)) begin
                    hue = HUE_360 - q9;
                end else begin
                    hue = q9;
                end
            end
            HUE_GREEN: begin
                hue = i_side.hue_neg ? (HUE_120 - q9) : (HUE_120 + q9);
            end
            HUE_BLUE: begin
                hue = i_side.hue_neg ? (HUE_240 - q9) : (HUE_240 + q9);
            end
            default: begin
                hue = 9'd0;
            end
        endcase
        if (i_side.hue_zero) begin
            hue = 9'd0;
        end
        sat = i_side.sat_zero ? 8'd0 : i_sat_q;
        hsv_red = ((hue <= i_cfg.hue_low_max) || (hue >= i_cfg.hue_high_min))
               && (sat > i_cfg.sat_min) && (i_side.mx > i_cfg.value_min);

        n_crop = i_side.pix;
        n_feat = {i_side.r, i_side.g, i_side.b};
        case (i_cfg.mode)
            MODE_SIMPLE: begin
                if (i_side.simple_red) begin
                    n_crop = RED_CROP;
                    n_feat = RED_FEATURE;
                end
            end
            MODE_HSV: begin
                if (hsv_red) begin
                    n_crop = RED_CROP;
                    n_feat = RED_FEATURE;
                end else begin
                    n_feat = {i_side.gray, i_side.gray, i_side.gray};
                end
            end
            default: begin
                n_crop = i_side.pix;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_crop <= n_crop;
            r_feat <= n_feat;
            r_idx  <= i_side.idx;
            r_last <= i_side.last;
        end
    end

    assign o_valid        = r_valid;
    assign o_disp_pixel   = r_crop;
    assign o_feature_rgb  = r_feat;
    assign o_crop_index   = r_idx;
    assign o_last_of_crop = r_last;

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the crop window and red-mask pixel pipeline. Camera
// beats with random colours and positions are pushed through the valid/ready
// input while the result channel stalls at random. Every accepted beat is
// run through a local model of the crop and mask, and each result beat is
// checked against the oldest prediction. Register settings change between
// phases, once the pipeline has drained.
// ----------------------------------------------------------------------------
module testbench;
    import pcrm_pkg::*;

    localparam int FRAME_W = 160;
    localparam int FRAME_H = 120;
    localparam int CROP_W  = 96;
    localparam int CROP_H  = 96;
    localparam int WIN_X0  = (FRAME_W >= CROP_W) ? (FRAME_W - CROP_W) / 2 : 0;
    localparam int WIN_Y0  = (FRAME_H >= CROP_H) ? (FRAME_H - CROP_H) / 2 : 0;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 3'd7;

    localparam int DRAIN_CYCLES = 12;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int REPORT_MAX   = 10;

    typedef struct packed {
        logic [15:0] pix;
        logic [7:0]  col;
        logic [6:0]  row;
    } cam_beat_t;

    typedef struct packed {
        logic [15:0] disp_pixel;
        logic [23:0] feature;
        logic [13:0] index;
        logic        last;
    } crop_result_t;

    logic                  i_clk          = 1'b0;
    logic                  i_rst_n        = 1'b0;
    logic                  i_in_valid     = 1'b0;
    logic                  o_in_ready;
    logic [15:0]           i_pixel        = '0;
    logic [7:0]            i_col          = '0;
    logic [6:0]            i_row          = '0;
    logic                  o_out_valid;
    logic                  i_out_ready    = 1'b0;
    logic [15:0]           o_disp_pixel;
    logic [23:0]           o_feature_rgb;
    logic [13:0]           o_crop_index;
    logic                  o_last_of_crop;
    logic                  i_cfg_valid    = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index    = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data     = '0;

    cam_beat_t    pixel_backlog[$];
    crop_result_t expected_crops[$];
    t_cfg         mask_cfg;
    logic         in_taken    = 1'b0;
    bit           steady_flow = 1'b0;
    int           err_count   = 0;
    int           cycle_count = 0;

    pixel_crop_red_mask_preprocess #(
        .FRAME_WIDTH  (FRAME_W),
        .FRAME_HEIGHT (FRAME_H),
        .CROP_WIDTH   (CROP_W),
        .CROP_HEIGHT  (CROP_H)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_pixel        (i_pixel),
        .i_col          (i_col),
        .i_row          (i_row),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_disp_pixel   (o_disp_pixel),
        .o_feature_rgb  (o_feature_rgb),
        .o_crop_index   (o_crop_index),
        .o_last_of_crop (o_last_of_crop),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // Returns 1 when the beat lies inside the crop window, with the result
    // it should produce under the given register settings.
    function automatic bit crop_and_mask(input cam_beat_t bt, input t_cfg cfg,
                                         output crop_result_t res);
        int cx, cy, r, g, b, mx, mn, d, hue, sat, gy;
        bit red;
        res = '0;
        if (int'(bt.col) >= FRAME_W || int'(bt.row) >= FRAME_H) return 1'b0;
        if (int'(bt.col) < WIN_X0 || int'(bt.row) < WIN_Y0) return 1'b0;
        cx = int'(bt.col) - WIN_X0;
        cy = int'(bt.row) - WIN_Y0;
        if (cx >= CROP_W || cy >= CROP_H) return 1'b0;

        r = {bt.pix[15:11], bt.pix[15:13]};
        g = {bt.pix[10:5], bt.pix[10:9]};
        b = {bt.pix[4:0], bt.pix[4:2]};

        res.disp_pixel = bt.pix;
        res.feature    = {8'(r), 8'(g), 8'(b)};
        res.index      = 14'(cy * CROP_W + cx);
        res.last       = (cx == CROP_W - 1) && (cy == CROP_H - 1);

        case (cfg.mode)
            MODE_SIMPLE: begin
                if (r > int'(cfg.simple_red_min) && r > g + int'(cfg.simple_margin)
                        && r > b + int'(cfg.simple_margin)) begin
                    res.disp_pixel = RED_CROP;
                    res.feature    = RED_FEATURE;
                end
            end
            MODE_HSV: begin
                mx  = (r > g) ? ((r > b) ? r : b) : ((g > b) ? g : b);
                mn  = (r < g) ? ((r < b) ? r : b) : ((g < b) ? g : b);
                d   = mx - mn;
                sat = (mx == 0) ? 0 : (255 * d) / mx;
                hue = 0;
                // Integer division truncates towards zero, as the hardware does.
                if (d > 0) begin
                    if (mx == r) begin
                        hue = (60 * (g - b)) / d;
                        if (hue < 0) hue += 360;
                    end else if (mx == g) begin
                        hue = (60 * (b - r)) / d + 120;
                    end else begin
                        hue = (60 * (r - g)) / d + 240;
                    end
                end
                red = (hue <= int'(cfg.hue_low_max) || hue >= int'(cfg.hue_high_min))
                    && sat > int'(cfg.sat_min) && mx > int'(cfg.value_min);
                if (red) begin
                    res.disp_pixel = RED_CROP;
                    res.feature    = RED_FEATURE;
                end else begin
                    gy = (19595 * r + 38470 * g + 7471 * b) >>> 16;
                    res.feature = {8'(gy), 8'(gy), 8'(gy)};
                end
            end
            default: begin
            end
        endcase
        return 1'b1;
    endfunction

    function automatic cam_beat_t random_beat();
        cam_beat_t   bt;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        // A share of strongly red colours so that the mask actually fires.
        if (pick < 30) begin
            bt.pix = {5'($urandom_range(18, 31)), 6'($urandom_range(0, 24)),
                      5'($urandom_range(0, 12))};
        end else begin
            bt.pix = 16'($urandom);
        end
        pick = $urandom_range(0, 99);
        if (pick < 75) begin
            bt.col = 8'(WIN_X0 + $urandom_range(0, CROP_W - 1));
            bt.row = 7'(WIN_Y0 + $urandom_range(0, CROP_H - 1));
        end else if (pick < 85) begin
            // Just inside or just outside one of the window borders.
            case ($urandom_range(0, 3))
                0: bt.col = 8'(WIN_X0 - 1);
                1: bt.col = 8'(WIN_X0);
                2: bt.col = 8'(WIN_X0 + CROP_W - 1);
                default: bt.col = 8'(WIN_X0 + CROP_W);
            endcase
            case ($urandom_range(0, 3))
                0: bt.row = 7'(WIN_Y0 - 1);
                1: bt.row = 7'(WIN_Y0);
                2: bt.row = 7'(WIN_Y0 + CROP_H - 1);
                default: bt.row = 7'(WIN_Y0 + CROP_H);
            endcase
        end else begin
            bt.col = 8'($urandom);
            bt.row = 7'($urandom);
        end
        return bt;
    endfunction

    task automatic queue_beat(input logic [15:0] pix, input int col, input int row);
        pixel_backlog.push_back('{pix: pix, col: 8'(col), row: 7'(row)});
    endtask

    // Waits until every queued beat has gone in and every result has come
    // out, then lets the pipeline settle for beats that produced nothing.
    task automatic drain();
        do @(posedge i_clk);
        while (pixel_backlog.size() != 0 || i_in_valid || expected_crops.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(input int n_beats);
        int k;
        for (k = 0; k < n_beats; k++) pixel_backlog.push_back(random_beat());
        drain();
    endtask

    // Input driver: a new beat only once the previous one has been taken.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_taken) begin
            if (pixel_backlog.size() != 0 && (steady_flow || $urandom_range(0, 99) >= 16)) begin
                cam_beat_t bt;
                bt = pixel_backlog.pop_front();
                i_in_valid <= 1'b1;
                i_pixel    <= bt.pix;
                i_col      <= bt.col;
                i_row      <= bt.row;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        i_out_ready <= steady_flow || ($urandom_range(0, 99) >= 16);
    end

    // Monitor: tracks register writes, predicts each accepted beat and checks
    // each result beat.
    always @(posedge i_clk) begin
        crop_result_t want;
        bit           bad;
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
        in_taken <= i_in_valid && o_in_ready;
        if (!i_rst_n) begin
            mask_cfg.mode           = RST_MODE;
            mask_cfg.simple_red_min = RST_SIMPLE_RED_MIN;
            mask_cfg.simple_margin  = RST_SIMPLE_MARGIN;
            mask_cfg.hue_low_max    = RST_HUE_LOW_MAX;
            mask_cfg.hue_high_min   = RST_HUE_HIGH_MIN;
            mask_cfg.sat_min        = RST_SAT_MIN;
            mask_cfg.value_min      = RST_VALUE_MIN;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_MODE:           mask_cfg.mode           = t_mode'(i_cfg_data[1:0]);
                    CFG_SIMPLE_RED_MIN: mask_cfg.simple_red_min = i_cfg_data[7:0];
                    CFG_SIMPLE_MARGIN:  mask_cfg.simple_margin  = i_cfg_data[7:0];
                    CFG_HUE_LOW_MAX:    mask_cfg.hue_low_max    = i_cfg_data[8:0];
                    CFG_HUE_HIGH_MIN:   mask_cfg.hue_high_min   = i_cfg_data[8:0];
                    CFG_SAT_MIN:        mask_cfg.sat_min        = i_cfg_data[7:0];
                    CFG_VALUE_MIN:      mask_cfg.value_min      = i_cfg_data[7:0];
                    default: begin
                    end
                endcase
            end
            if (i_in_valid && o_in_ready) begin
                if (crop_and_mask('{pix: i_pixel, col: i_col, row: i_row}, mask_cfg, want))
                    expected_crops.push_back(want);
            end
            if (o_out_valid && i_out_ready) begin
                if (expected_crops.size() == 0) begin
                    err_count++;
                    if (err_count <= REPORT_MAX)
                        $display("unexpected result beat: pixel %h feature %h index %0d last %0b",
                                 o_disp_pixel, o_feature_rgb, o_crop_index, o_last_of_crop);
                end else begin
                    want = expected_crops.pop_front();
                    bad  = (o_disp_pixel !== want.disp_pixel) || (o_feature_rgb !== want.feature)
                        || (o_crop_index !== want.index) || (o_last_of_crop !== want.last);
                    if (bad) begin
                        err_count++;
                        if (err_count <= REPORT_MAX)
                            $display("mismatch: expected %h %h %0d %0b, got %h %h %0d %0b",
                                     want.disp_pixel, want.feature, want.index, want.last,
                                     o_disp_pixel, o_feature_rgb, o_crop_index, o_last_of_crop);
                    end
                end
            end
        end
    end

    initial begin
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed beats under the reset settings (HSV mask).
        queue_beat(16'h0000, WIN_X0, WIN_Y0);                           // first pixel, black
        queue_beat(16'hFFFF, WIN_X0 + CROP_W - 1, WIN_Y0 + CROP_H - 1); // last pixel, white
        queue_beat(16'hF800, WIN_X0 + 1, WIN_Y0);                       // pure red
        queue_beat(16'h07E0, WIN_X0 + 2, WIN_Y0);                       // pure green
        queue_beat(16'h001F, WIN_X0 + 3, WIN_Y0);                       // pure blue
        queue_beat(16'hF81F, WIN_X0 + 4, WIN_Y0);                       // red and blue tie
        queue_beat(16'hFFE0, WIN_X0 + 5, WIN_Y0);                       // red and green tie
        queue_beat(16'hF801, WIN_X0 + 6, WIN_Y0);                       // hue wraps below zero
        queue_beat(16'hF820, WIN_X0 + 7, WIN_Y0);                       // hue just above zero
        queue_beat(16'h8000, WIN_X0 + 8, WIN_Y0 + 1);                   // dark red
        queue_beat(16'h3800, WIN_X0 + 9, WIN_Y0 + 1);                   // red below value floor
        queue_beat(16'h0821, WIN_X0 + 10, WIN_Y0 + 2);                  // near-black grey
        queue_beat(16'h5555, WIN_X0 + CROP_W - 1, WIN_Y0);              // top-right corner
        queue_beat(16'hAAAA, WIN_X0, WIN_Y0 + CROP_H - 1);              // bottom-left corner
        queue_beat(16'hF800, WIN_X0 - 1, 50);                           // left of window
        queue_beat(16'hF800, WIN_X0 + CROP_W, 50);                      // right of window
        queue_beat(16'hF800, 50, WIN_Y0 - 1);                           // above window
        queue_beat(16'hF800, 50, WIN_Y0 + CROP_H);                      // below window
        queue_beat(16'hF800, FRAME_W, 50);                              // beyond frame width
        queue_beat(16'hF800, 50, FRAME_H);                              // beyond frame height
        queue_beat(16'hFFFF, 255, 127);                                 // largest coordinates
        queue_beat(16'h7BEF, 0, 0);                                     // frame origin
        drain();

        run_phase(200);
        // Second half of the same setting, after a full pause of the sender.
        run_phase(60);

        write_reg(CFG_MODE, MODE_PASS);
        run_phase(80);
        write_reg(CFG_MODE, MODE_PASS_ALT);
        run_phase(60);

        write_reg(CFG_MODE, MODE_SIMPLE);
        run_phase(80);
        write_reg(CFG_SIMPLE_RED_MIN, 9'd0);
        write_reg(CFG_SIMPLE_MARGIN, 9'd0);
        run_phase(80);
        // Wider data than the register: only the low byte counts.
        write_reg(CFG_SIMPLE_RED_MIN, 9'h1FF);
        write_reg(CFG_SIMPLE_MARGIN, 9'h1FF);
        run_phase(40);
        write_reg(CFG_SIMPLE_RED_MIN, 9'd100);
        write_reg(CFG_SIMPLE_MARGIN, 9'd30);
        run_phase(100);

        // Mode register keeps two bits: this selects the HSV mask.
        write_reg(CFG_MODE, 9'h1FE);
        write_reg(CFG_HUE_LOW_MAX, 9'd0);
        write_reg(CFG_HUE_HIGH_MIN, 9'd359);
        write_reg(CFG_SAT_MIN, 9'd0);
        write_reg(CFG_VALUE_MIN, 9'd0);
        run_phase(100);
        write_reg(CFG_HUE_LOW_MAX, 9'h1FF);
        write_reg(CFG_HUE_HIGH_MIN, 9'd0);
        write_reg(CFG_SAT_MIN, 9'h1FF);
        write_reg(CFG_VALUE_MIN, 9'h1FF);
        run_phase(60);

        write_reg(CFG_HUE_LOW_MAX, 9'd60);
        write_reg(CFG_HUE_HIGH_MIN, 9'd300);
        write_reg(CFG_SAT_MIN, 9'd50);
        write_reg(CFG_VALUE_MIN, 9'd30);
        steady_flow = 1'b1;
        run_phase(200);
        steady_flow = 1'b0;

        // A write past the last register must leave every setting alone.
        write_reg(CFG_IDX_UNUSED, 9'h1FF);
        run_phase(70);

        if (expected_crops.size() != 0) err_count += expected_crops.size();
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/pcrm_pkg.sv
sv/pcrm_front.sv
sv/pcrm_prep.sv
sv/pcrm_div.sv
sv/pcrm_back.sv
sv/pixel_crop_red_mask_preprocess.sv
tb/testbench.sv
